FILE: hw/rtl/qte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_pkg
// Shared types, constants and step functions of the quaternion to Euler
// angle pipeline.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int unsigned ITER      = 14;  // CORDIC iterations, up to 17 (atan table depth)
  localparam int unsigned LANES     = 3;   // roll, pitch, yaw
  localparam int unsigned IW        = 16;  // quaternion component width
  localparam int unsigned PW        = 32;  // product width
  localparam int unsigned CW        = 37;  // CORDIC vector width
  localparam int unsigned ZW        = 20;  // CORDIC angle width, Q16
  localparam int unsigned MW        = 28;  // |sin pitch| width when not clamped
  localparam int unsigned SQ_STEPS  = 29;  // root bits of isqrt
  localparam int unsigned SQ_VW     = 58;  // isqrt remainder / root work width
  localparam int unsigned SQ_RW     = 29;  // root width

  localparam logic signed [CW-1:0] ONE_Q28     = 37'sd268435456;
  localparam logic signed [ZW-1:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [ZW-1:0] PI_Q13      = 20'sd25736;
  localparam logic signed [ZW-1:0] HALF_PI_Q13 = 20'sd12868;
  localparam logic [SQ_VW-1:0]     ONE_Q56     = 58'd1 << 56;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } vec_t;

  typedef struct packed {
    vec_t                 roll;
    vec_t                 yaw;
    logic signed [CW-1:0] sinp;
  } prod_t;

  typedef struct packed {
    vec_t                 roll;
    vec_t                 yaw;
    logic signed [CW-1:0] sinp;
    logic                 clamp;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic [SQ_RW-1:0]   root;
  } sqrt_t;

  typedef struct packed {
    logic clamp;
    logic neg;
  } aux_t;

  function automatic logic signed [ZW-1:0] atan_q16(input int unsigned i);
    logic signed [ZW-1:0] a;
    unique case (i)
      0:       a = 20'sd51472;
      1:       a = 20'sd30386;
      2:       a = 20'sd16055;
      3:       a = 20'sd8150;
      4:       a = 20'sd4091;
      5:       a = 20'sd2047;
      6:       a = 20'sd1024;
      7:       a = 20'sd512;
      8:       a = 20'sd256;
      9:       a = 20'sd128;
      10:      a = 20'sd64;
      11:      a = 20'sd32;
      12:      a = 20'sd16;
      13:      a = 20'sd8;
      14:      a = 20'sd4;
      15:      a = 20'sd2;
      16:      a = 20'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Fold left half plane into right half plane.
  function automatic vec_t prerot(input logic signed [CW-1:0] y,
                                  input logic signed [CW-1:0] x);
    vec_t v;
    v.zero = (x == '0) && (y == '0);
    v.x    = x;
    v.y    = y;
    v.z    = '0;
    if (x < 0) begin
      if (y >= 0) begin
        v.x = y;
        v.y = -x;
        v.z = HALF_PI_Q16;
      end else begin
        v.x = -y;
        v.y = x;
        v.z = -HALF_PI_Q16;
      end
    end
    return v;
  endfunction

  // One vectoring iteration.
  function automatic vec_t cordic_step(input vec_t v, input int unsigned i);
    vec_t r;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    r  = v;
    dx = v.y >>> i;
    dy = v.x >>> i;
    if (v.y > 0) begin
      r.x = v.x + dx;
      r.y = v.y - dy;
      r.z = v.z + atan_q16(i);
    end else begin
      r.x = v.x - dx;
      r.y = v.y + dy;
      r.z = v.z - atan_q16(i);
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/qte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_if
// Quaternion and Euler angle channels, valid/ready.
// ----------------------------------------------------------------------------
interface quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface euler_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [14:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  logic               pitch_clamped;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                  input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                  output ready);
endinterface

FILE: hw/rtl/qte_prod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_prod
// Products, then sine/cosine sums and half plane fold for roll and yaw, and the pitch sine.
// ----------------------------------------------------------------------------
module qte_prod import qte_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [IW-1:0] w_i,
  input  logic signed [IW-1:0] x_i,
  input  logic signed [IW-1:0] y_i,
  input  logic signed [IW-1:0] z_i,
  output logic                 valid_o,
  output prod_t                data_o
);

  logic                 v1_q, v2_q;
  logic signed [PW-1:0] wx_q, yz_q, xx_q, yy_q, wy_q, zx_q, wz_q, xy_q, zz_q;
  prod_t                data_d, data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wx_q <= PW'(w_i * x_i);
      yz_q <= PW'(y_i * z_i);
      xx_q <= PW'(x_i * x_i);
      yy_q <= PW'(y_i * y_i);
      wy_q <= PW'(w_i * y_i);
      zx_q <= PW'(z_i * x_i);
      wz_q <= PW'(w_i * z_i);
      xy_q <= PW'(x_i * y_i);
      zz_q <= PW'(z_i * z_i);
    end
  end

  always_comb begin
    logic signed [CW-1:0] sinr, cosr, siny, cosy;
    sinr        = (CW'(wx_q) + CW'(yz_q)) <<< 1;
    cosr        = ONE_Q28 - ((CW'(xx_q) + CW'(yy_q)) <<< 1);
    siny        = (CW'(wz_q) + CW'(xy_q)) <<< 1;
    cosy        = ONE_Q28 - ((CW'(yy_q) + CW'(zz_q)) <<< 1);
    data_d.roll = prerot(sinr, cosr);
    data_d.yaw  = prerot(siny, cosy);
    data_d.sinp = (CW'(wy_q) - CW'(zx_q)) <<< 1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) data_q <= data_d;
  end

  assign valid_o = v2_q;
  assign data_o  = data_q;

endmodule

FILE: hw/rtl/qte_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_isqrt
// Pitch cosine: floor(sqrt(2^56 - s^2)), one root bit per stage.
// ----------------------------------------------------------------------------
module qte_isqrt import qte_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  prod_t data_i,
  output logic  valid_o,
  output sqrt_t data_o
);

  // Stage A: clamp test and magnitude. Stage B: square. Stage C: 2^56 - s^2.
  logic              va_q, vb_q, vc_q;
  side_t             sa_q, sb_q, sc_q;
  logic [MW-1:0]     mag_q;
  logic [2*MW-1:0]   sq_q;
  logic [SQ_VW-1:0]  rem0_q;
  side_t             side_d;
  logic [MW-1:0]     mag_d;

  always_comb begin
    logic signed [CW-1:0] a;
    side_d.roll  = data_i.roll;
    side_d.yaw   = data_i.yaw;
    side_d.sinp  = data_i.sinp;
    side_d.clamp = (data_i.sinp >= ONE_Q28) || (data_i.sinp <= -ONE_Q28);
    a            = data_i.sinp[CW-1] ? -data_i.sinp : data_i.sinp;
    mag_d        = side_d.clamp ? '0 : a[MW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sa_q   <= side_d;
      mag_q  <= mag_d;
      sb_q   <= sa_q;
      sq_q   <= mag_q * mag_q;
      sc_q   <= sb_q;
      rem0_q <= ONE_Q56 - SQ_VW'(sq_q);
    end
  end

  logic             vld_q [SQ_STEPS];
  logic [SQ_VW-1:0] rem_q [SQ_STEPS];
  logic [SQ_VW-1:0] res_q [SQ_STEPS];
  side_t            side_q[SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    logic             vld_p;
    logic [SQ_VW-1:0] rem_p, res_p, rem_d, res_d, bit_c, trial;
    side_t            side_p;

    if (k == 0) begin : g_first
      assign vld_p  = vc_q;
      assign rem_p  = rem0_q;
      assign res_p  = '0;
      assign side_p = sc_q;
    end else begin : g_next
      assign vld_p  = vld_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign res_p  = res_q[k-1];
      assign side_p = side_q[k-1];
    end

    always_comb begin
      bit_c = SQ_VW'(1) << (2 * (SQ_STEPS - 1 - k));
      trial = res_p + bit_c;
      if (rem_p >= trial) begin
        rem_d = rem_p - trial;
        res_d = (res_p >> 1) + bit_c;
      end else begin
        rem_d = rem_p;
        res_d = res_p >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[k] <= 1'b0;
      else if (en_i) vld_q[k] <= vld_p;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        res_q[k]  <= res_d;
        side_q[k] <= side_p;
      end
    end
  end

  assign valid_o     = vld_q[SQ_STEPS-1];
  assign data_o.side = side_q[SQ_STEPS-1];
  assign data_o.root = res_q[SQ_STEPS-1][SQ_RW-1:0];

endmodule

FILE: hw/rtl/qte_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_cordic
// Three-lane vectoring CORDIC, one iteration per stage.
// ----------------------------------------------------------------------------
module qte_cordic import qte_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  vec_t [LANES-1:0] lane_i,
  input  aux_t             aux_i,
  output logic             valid_o,
  output vec_t [LANES-1:0] lane_o,
  output aux_t             aux_o
);

  logic             vld_q  [ITER];
  vec_t [LANES-1:0] lane_q [ITER];
  aux_t             aux_q  [ITER];

  for (genvar s = 0; s < ITER; s++) begin : g_stage
    logic             vld_p;
    vec_t [LANES-1:0] lane_p;
    aux_t             aux_p;

    if (s == 0) begin : g_first
      assign vld_p  = valid_i;
      assign lane_p = lane_i;
      assign aux_p  = aux_i;
    end else begin : g_next
      assign vld_p  = vld_q[s-1];
      assign lane_p = lane_q[s-1];
      assign aux_p  = aux_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[s] <= 1'b0;
      else if (en_i) vld_q[s] <= vld_p;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < LANES; l++) begin
          lane_q[s][l] <= cordic_step(lane_p[l], s);
        end
        aux_q[s] <= aux_p;
      end
    end
  end

  assign valid_o = vld_q[ITER-1];
  assign lane_o  = lane_q[ITER-1];
  assign aux_o   = aux_q[ITER-1];

endmodule

FILE: hw/rtl/quaternion_to_euler_angles.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Quaternion (Q2.14) to roll/yaw (Q3.13) and pitch (Q2.13), fully pipelined.
// ----------------------------------------------------------------------------
//  channel   dir   modport         payload
//  quat_i    in    quat_if.sink    quat_w, quat_x, quat_y, quat_z
//  euler_o   out   euler_if.source roll_angle, pitch_angle, yaw_angle,
//                                  pitch_clamped
//
//  One transaction in per cycle while quat_i.ready is high. Stages in order:
//  products, sums and fold, clamp test and magnitude, square, 2^56 - s^2,
//  one isqrt bit per stage, one CORDIC step per stage, output register.
//  The isqrt chain is the longest part. Reset clears only the valid bits.
//  A stall at euler_o freezes every stage at once; quat_i.ready drops only
//  while the output holds an untaken result.
module quaternion_to_euler_angles import qte_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  quat_if.sink           quat_i,
  euler_if.source        euler_o
);

  logic             en;
  logic             out_vld_q;
  logic             prod_vld, sq_vld, cor_vld;
  prod_t            prod;
  sqrt_t            sq;
  vec_t [LANES-1:0] lane_in, lane_out;
  aux_t             aux_in, aux_out;

  // Global pipeline enable: everything moves when the output slot is free or being taken.
  assign en           = !out_vld_q || euler_o.ready;
  assign quat_i.ready = en;

  qte_prod u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (quat_i.valid),
    .w_i     (quat_i.quat_w),
    .x_i     (quat_i.quat_x),
    .y_i     (quat_i.quat_y),
    .z_i     (quat_i.quat_z),
    .valid_o (prod_vld),
    .data_o  (prod)
  );

  qte_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (prod_vld),
    .data_i  (prod),
    .valid_o (sq_vld),
    .data_o  (sq)
  );

  // Lane 0 roll, lane 1 pitch (cosine from isqrt, always positive), lane 2 yaw.
  always_comb begin
    lane_in[0]    = sq.side.roll;
    lane_in[1]    = prerot(sq.side.sinp, signed'({{(CW - SQ_RW){1'b0}}, sq.root}));
    lane_in[2]    = sq.side.yaw;
    aux_in.clamp  = sq.side.clamp;
    aux_in.neg    = sq.side.sinp[CW-1];
  end

  qte_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .lane_i  (lane_in),
    .aux_i   (aux_in),
    .valid_o (cor_vld),
    .lane_o  (lane_out),
    .aux_o   (aux_out)
  );

  // Round Q16 angle to Q3.13 and saturate.
  function automatic logic signed [ZW-1:0] finish(input vec_t v,
                                                  input logic signed [ZW-1:0] lim);
    logic signed [ZW-1:0] a;
    if (v.zero) a = '0;
    else        a = (v.z + ZW'(4)) >>> 3;
    if (a > lim)       a = lim;
    else if (a < -lim) a = -lim;
    return a;
  endfunction

  logic signed [ZW-1:0] roll_d, pitch_d, yaw_d;
  logic signed [15:0]   roll_q, yaw_q;
  logic signed [14:0]   pitch_q;
  logic                 clamp_q;

  always_comb begin
    roll_d = finish(lane_out[0], PI_Q13);
    yaw_d  = finish(lane_out[2], PI_Q13);
    if (aux_out.clamp) begin
      pitch_d = aux_out.neg ? -HALF_PI_Q13 : HALF_PI_Q13;
    end else begin
      pitch_d = finish(lane_out[1], HALF_PI_Q13);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= cor_vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= roll_d[15:0];
      pitch_q <= pitch_d[14:0];
      yaw_q   <= yaw_d[15:0];
      clamp_q <= aux_out.clamp;
    end
  end

  assign euler_o.valid         = out_vld_q;
  assign euler_o.roll_angle    = roll_q;
  assign euler_o.pitch_angle   = pitch_q;
  assign euler_o.yaw_angle     = yaw_q;
  assign euler_o.pitch_clamped = clamp_q;

endmodule
